// ===== hdl/ppp_pkg.sv =====
package ppp_pkg;

    // Fixed-point formats.
    localparam int AXIS_BITS      = 21;
    localparam int AXIS_FRAC_BITS = 16;
    localparam int DIFF_BITS      = 33;
    localparam int PROD_BITS      = DIFF_BITS + AXIS_BITS;
    localparam int SUM_BITS       = PROD_BITS + 2;
    localparam int DEPTH_BITS     = SUM_BITS - AXIS_FRAC_BITS;
    localparam int NUM_BITS       = 64;
    localparam int DEN_BITS       = 48;
    localparam int QUO_BITS       = 32;

    // The divider has one load stage and one stage per quotient bit.
    localparam int DIV_STEPS      = QUO_BITS;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_CAM_X  = 3'd0,
        REG_CAM_Y  = 3'd1,
        REG_CAM_Z  = 3'd2,
        REG_VIEW   = 3'd3,
        REG_LEFT   = 3'd4,
        REG_UP     = 3'd5,
        REG_CLIP   = 3'd6,
        REG_IMAGE  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic [62:0]        view_dir;
        logic [62:0]        left_axis;
        logic [62:0]        up_axis;
        logic [31:0]        near_depth;
        logic [31:0]        far_depth;
        logic [11:0]        width;
        logic [11:0]        height;
        logic [31:0]        radius_scale;
    } cfg_t;

    // Front-end results handed to the dividers.
    typedef struct packed {
        logic                valid;
        logic                clip;
        logic                neg_x;
        logic                neg_y;
        logic [NUM_BITS-1:0] num_x;
        logic [NUM_BITS-1:0] num_y;
        logic [NUM_BITS-1:0] num_r;
        logic [DEN_BITS-1:0] den_xy;
        logic [DEN_BITS-1:0] den_r;
    } front_t;

    // Sideband that travels beside the dividers.
    typedef struct packed {
        logic valid;
        logic clip;
        logic neg_x;
        logic neg_y;
    } side_t;

endpackage

// ===== hdl/ppp_regs.sv =====
module ppp_regs (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [5:0]      paddr,
    input  logic [63:0]     pwdata,
    output logic [63:0]     prdata,
    output logic            pready,
    output ppp_pkg::cfg_t   cfg
);
    import ppp_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_CAM_X: cfg_reg.cam_x     <= pwdata[31:0];
                REG_CAM_Y: cfg_reg.cam_y     <= pwdata[31:0];
                REG_CAM_Z: cfg_reg.cam_z     <= pwdata[31:0];
                REG_VIEW:  cfg_reg.view_dir  <= pwdata[62:0];
                REG_LEFT:  cfg_reg.left_axis <= pwdata[62:0];
                REG_UP:    cfg_reg.up_axis   <= pwdata[62:0];
                REG_CLIP: begin
                    cfg_reg.near_depth <= pwdata[31:0];
                    cfg_reg.far_depth  <= pwdata[63:32];
                end
                REG_IMAGE: begin
                    cfg_reg.width        <= pwdata[11:0];
                    cfg_reg.height       <= pwdata[23:12];
                    cfg_reg.radius_scale <= pwdata[55:24];
                end
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (idx)
            REG_CAM_X: prdata = {32'd0, cfg_reg.cam_x};
            REG_CAM_Y: prdata = {32'd0, cfg_reg.cam_y};
            REG_CAM_Z: prdata = {32'd0, cfg_reg.cam_z};
            REG_VIEW:  prdata = {1'b0, cfg_reg.view_dir};
            REG_LEFT:  prdata = {1'b0, cfg_reg.left_axis};
            REG_UP:    prdata = {1'b0, cfg_reg.up_axis};
            REG_CLIP:  prdata = {cfg_reg.far_depth, cfg_reg.near_depth};
            REG_IMAGE: prdata = {8'd0, cfg_reg.radius_scale, cfg_reg.height, cfg_reg.width};
            default:   prdata = '0;
        endcase
    end

endmodule

// ===== hdl/ppp_front.sv =====
module ppp_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              enable,
    input  logic              in_valid,
    input  logic [127:0]      in_data,
    input  ppp_pkg::cfg_t     cfg,
    output ppp_pkg::front_t   front
);
    import ppp_pkg::*;

    // Stage 1: offset from the camera.
    logic                        v1_reg;
    logic signed [DIFF_BITS-1:0] d_reg [0:2];
    logic [31:0]                 rad1_reg;

    // Stage 2: products.
    logic                        v2_reg;
    logic signed [PROD_BITS-1:0] pv_reg [0:2];
    logic signed [PROD_BITS-1:0] pl_reg [0:2];
    logic signed [PROD_BITS-1:0] pu_reg [0:2];
    logic [63:0]                 rs2_reg;

    // Stage 3: depth and axis terms.
    logic                         v3_reg;
    logic signed [DEPTH_BITS-1:0] dep3_reg;
    logic signed [DEPTH_BITS-1:0] lt3_reg;
    logic signed [DEPTH_BITS-1:0] ut3_reg;
    logic [63:0]                  rs3_reg;

    // Stage 4: clip test and numerator sums.
    logic                       v4_reg;
    logic                       clip4_reg;
    logic signed [DEPTH_BITS:0] sx4_reg;
    logic signed [DEPTH_BITS:0] sy4_reg;
    logic [DEPTH_BITS-1:0]      dep4_reg;
    logic [63:0]                rs4_reg;

    front_t front_reg;

    logic signed [DIFF_BITS-1:0]  d_next [0:2];
    logic signed [SUM_BITS-1:0]   sv_sum, sl_sum, su_sum;
    logic signed [DEPTH_BITS-1:0] near_s, far_s;
    logic signed [53:0]           px, py;
    logic [53:0]                  mag_x, mag_y;

    // Point minus camera position.
    assign d_next[0] = $signed(in_data[31:0])  - cfg.cam_x;
    assign d_next[1] = $signed(in_data[63:32]) - cfg.cam_y;
    assign d_next[2] = $signed(in_data[95:64]) - cfg.cam_z;

    // Exact dot products; taking the upper bits floors the scaled sum.
    assign sv_sum = pv_reg[0] + pv_reg[1] + pv_reg[2];
    assign sl_sum = pl_reg[0] + pl_reg[1] + pl_reg[2];
    assign su_sum = pu_reg[0] + pu_reg[1] + pu_reg[2];

    assign near_s = $signed({{(DEPTH_BITS-32){1'b0}}, cfg.near_depth});
    assign far_s  = $signed({{(DEPTH_BITS-32){1'b0}}, cfg.far_depth});

    // Scale by the image size; a negative value is inverted so that
    // the divider sees a magnitude and the floor comes out by inverting back.
    assign px    = sx4_reg * $signed({1'b0, cfg.width});
    assign py    = sy4_reg * $signed({1'b0, cfg.height});
    assign mag_x = px[53] ? ~px : px;
    assign mag_y = py[53] ? ~py : py;

    assign front = front_reg;

    // Valid bits and datapath registers advance with the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            front_reg.valid <= 1'b0;
        end else if (enable) begin
            v1_reg          <= in_valid;
            v2_reg          <= v1_reg;
            v3_reg          <= v2_reg;
            v4_reg          <= v3_reg;
            front_reg.valid <= v4_reg;

            for (int i = 0; i < 3; i++) begin
                d_reg[i]  <= d_next[i];
                pv_reg[i] <= d_reg[i] *
                    $signed(cfg.view_dir[i*AXIS_BITS +: AXIS_BITS]);
                pl_reg[i] <= d_reg[i] *
                    $signed(cfg.left_axis[i*AXIS_BITS +: AXIS_BITS]);
                pu_reg[i] <= d_reg[i] *
                    $signed(cfg.up_axis[i*AXIS_BITS +: AXIS_BITS]);
            end
            rad1_reg <= in_data[127:96];
            rs2_reg  <= rad1_reg * cfg.radius_scale;

            dep3_reg <= sv_sum[SUM_BITS-1:AXIS_FRAC_BITS];
            lt3_reg  <= sl_sum[SUM_BITS-1:AXIS_FRAC_BITS];
            ut3_reg  <= su_sum[SUM_BITS-1:AXIS_FRAC_BITS];
            rs3_reg  <= rs2_reg;

            clip4_reg <= (dep3_reg <= 0) || (dep3_reg < near_s) || (dep3_reg > far_s);
            sx4_reg   <= dep3_reg + lt3_reg;
            sy4_reg   <= dep3_reg + ut3_reg;
            dep4_reg  <= dep3_reg;
            rs4_reg   <= rs3_reg;

            // The inverted numerator of a negative value is the inverse of
            // the value times 128, so the low bits fill with ones.
            front_reg.clip   <= clip4_reg;
            front_reg.neg_x  <= px[53];
            front_reg.neg_y  <= py[53];
            front_reg.num_x  <= {4'd0, mag_x[52:0], {7{px[53]}}};
            front_reg.num_y  <= {4'd0, mag_y[52:0], {7{py[53]}}};
            front_reg.num_r  <= rs4_reg;
            front_reg.den_xy <= {{(DEN_BITS-DEPTH_BITS){1'b0}}, dep4_reg};
            front_reg.den_r  <= {dep4_reg, 8'd0};
        end
    end

endmodule

// ===== hdl/ppp_div.sv =====
module ppp_div (
    input  logic                          aclk,
    input  logic                          enable,
    input  logic [ppp_pkg::NUM_BITS-1:0]  num,
    input  logic [ppp_pkg::DEN_BITS-1:0]  den,
    output logic [ppp_pkg::QUO_BITS-1:0]  quo,
    output logic                          ovf
);
    import ppp_pkg::*;

    // One restoring step per stage; the upper half of the dividend
    // is loaded as the first partial remainder.
    logic [DEN_BITS-1:0] rem_reg [0:DIV_STEPS];
    logic [DEN_BITS-1:0] den_reg [0:DIV_STEPS];
    logic [QUO_BITS-1:0] low_reg [0:DIV_STEPS];
    logic [QUO_BITS-1:0] q_reg   [0:DIV_STEPS];
    logic                ovf_reg [0:DIV_STEPS];

    logic [DEN_BITS:0]   trial   [1:DIV_STEPS];
    logic [DEN_BITS:0]   diff    [1:DIV_STEPS];
    logic                ge      [1:DIV_STEPS];

    // Load stage: quotient overflows when the upper half reaches the divisor.
    always_ff @(posedge aclk) begin
        if (enable) begin
            rem_reg[0] <= {{(DEN_BITS-QUO_BITS){1'b0}}, num[NUM_BITS-1:QUO_BITS]};
            den_reg[0] <= den;
            low_reg[0] <= num[QUO_BITS-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= ({{(DEN_BITS-QUO_BITS){1'b0}}, num[NUM_BITS-1:QUO_BITS]} >= den);
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        assign trial[k] = {rem_reg[k-1], low_reg[k-1][QUO_BITS-1]};
        assign diff[k]  = trial[k] - {1'b0, den_reg[k-1]};
        assign ge[k]    = (trial[k] >= {1'b0, den_reg[k-1]});

        always_ff @(posedge aclk) begin
            if (enable) begin
                rem_reg[k] <= ge[k] ? diff[k][DEN_BITS-1:0] : trial[k][DEN_BITS-1:0];
                den_reg[k] <= den_reg[k-1];
                low_reg[k] <= {low_reg[k-1][QUO_BITS-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][QUO_BITS-2:0], ge[k]};
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo = q_reg[DIV_STEPS];
    assign ovf = ovf_reg[DIV_STEPS];

endmodule

// ===== hdl/perspective_point_projector.sv =====
// An accepted input transaction passes 5 front-end stages, 33 divider stages and 1 output
// register before its result appears on m_tvalid. Throughput: one point per cycle unless
// the output stalls; the dividers are fully pipelined, one quotient bit per stage.
// A stall on the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and sets every configuration
// register to zero.
module perspective_point_projector (
    input  logic         aclk,
    input  logic         aresetn,
    // Input: point_x, point_y, point_z, point_radius (32 bits each, from bit 0 up)
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,
    // Output: pixel_x, pixel_y, pixel_radius (32 bits each, from bit 0 up)
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,
    // Output flag: clipped
    output logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import ppp_pkg::*;

    cfg_t   cfg;
    front_t front;
    side_t  side_reg [0:DIV_STEPS];
    logic   enable;

    logic [QUO_BITS-1:0] qx, qy, qr;
    logic                ovx, ovy, ovr;

    logic                m_tvalid_reg;
    logic [95:0]         m_tdata_reg;
    logic                m_tuser_reg;

    logic signed [32:0]  floor_x, floor_y;
    logic signed [34:0]  y_full;
    logic signed [21:0]  y_base;
    logic [31:0]         pix_x, pix_y, pix_r;
    side_t               last;

    // The pipeline moves whenever the output register can take a result.
    assign enable   = m_tready | ~m_tvalid_reg;
    assign s_tready = enable;

    ppp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .enable   (enable),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .cfg      (cfg),
        .front    (front)
    );

    ppp_div u_div_x (
        .aclk (aclk), .enable (enable), .num (front.num_x), .den (front.den_xy),
        .quo (qx), .ovf (ovx)
    );

    ppp_div u_div_y (
        .aclk (aclk), .enable (enable), .num (front.num_y), .den (front.den_xy),
        .quo (qy), .ovf (ovy)
    );

    ppp_div u_div_r (
        .aclk (aclk), .enable (enable), .num (front.num_r), .den (front.den_r),
        .quo (qr), .ovf (ovr)
    );

    // Sideband delay line that matches the divider depth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                side_reg[k].valid <= 1'b0;
            end
        end else if (enable) begin
            side_reg[0] <= '{valid: front.valid, clip: front.clip,
                             neg_x: front.neg_x, neg_y: front.neg_y};
            for (int k = 1; k <= DIV_STEPS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign last = side_reg[DIV_STEPS];

    // Undo the inversion to get the floored quotients.
    assign floor_x = last.neg_x ? ~$signed({1'b0, qx}) : $signed({1'b0, qx});
    assign floor_y = last.neg_y ? ~$signed({1'b0, qy}) : $signed({1'b0, qy});
    assign y_base  = $signed({2'b00, cfg.height, 8'd0}) - 22'sd256;
    assign y_full  = y_base - floor_y;

    // Saturation of the three results.
    always_comb begin
        if (ovx) begin
            pix_x = last.neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (floor_x > 33'sh0_7FFF_FFFF) begin
            pix_x = 32'h7FFF_FFFF;
        end else if (floor_x < -33'sh0_8000_0000) begin
            pix_x = 32'h8000_0000;
        end else begin
            pix_x = floor_x[31:0];
        end

        if (ovy) begin
            pix_y = last.neg_y ? 32'h7FFF_FFFF : 32'h8000_0000;
        end else if (y_full > 35'sh0_7FFF_FFFF) begin
            pix_y = 32'h7FFF_FFFF;
        end else if (y_full < -35'sh0_8000_0000) begin
            pix_y = 32'h8000_0000;
        end else begin
            pix_y = y_full[31:0];
        end

        if (ovr) begin
            pix_r = 32'hFFFF_FFFF;
        end else if (qr == '0) begin
            pix_r = 32'd1;
        end else begin
            pix_r = qr;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (enable) begin
            m_tvalid_reg <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            m_tdata_reg <= last.clip ? 96'd0 : {pix_r, pix_y, pix_x};
            m_tuser_reg <= last.clip;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // A clipped result carries zero pixel fields.
    a_clip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 96'd0))
        else $error("clipped result with nonzero pixel fields");

    // A visible point never reports a zero radius.
    a_radius_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[95:64] != 32'd0))
        else $error("unclipped result with zero radius");

    // Input is held off exactly while the output register is full and stalled.
    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (m_tready || !m_tvalid))
        else $error("input ready does not follow output stall");

    // A stalled cycle moves nothing into the output register.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output changed during stall");

endmodule

// ===== bench/perspective_point_projector_test.sv =====
module perspective_point_projector_test;
    import ppp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One projected point as it leaves the block.
    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pr;
        logic        clip;
    } pixel_t;

    // Keeps a copy of the camera registers and the projections still owed by the block.
    class projection_board;
        logic [63:0] camera_regs[8];
        pixel_t      owed[$];
        int          errors;
        int          checked;
        int          clipped_seen;

        function new();
            foreach (camera_regs[i]) camera_regs[i] = '0;
            errors = 0;
            checked = 0;
            clipped_seen = 0;
        endfunction

        function longint axis_dot(longint dx, longint dy, longint dz, logic [63:0] packed_axis);
            longint sum;
            sum = dx * longint'($signed(packed_axis[20:0]))
                + dy * longint'($signed(packed_axis[41:21]))
                + dz * longint'($signed(packed_axis[62:42]));
            return sum >>> AXIS_FRAC_BITS;
        endfunction

        function longint div_floor(longint a, longint b);
            if (a >= 0) return a / b;
            return -((-(a + 1)) / b) - 1;
        endfunction

        function logic [31:0] clamp_s32(longint v);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
        endfunction

        // Work out the projection of one accepted point and queue it.
        function void note_point(logic [127:0] pt);
            longint dx, dy, dz, depth, lt, ut, xq, yq;
            longint nearv, farv, width, height;
            longint unsigned scale, radius, rq;
            pixel_t e;
            dx = longint'($signed(pt[31:0])) - longint'($signed(camera_regs[REG_CAM_X][31:0]));
            dy = longint'($signed(pt[63:32])) - longint'($signed(camera_regs[REG_CAM_Y][31:0]));
            dz = longint'($signed(pt[95:64])) - longint'($signed(camera_regs[REG_CAM_Z][31:0]));
            depth = axis_dot(dx, dy, dz, camera_regs[REG_VIEW]);
            nearv = longint'({32'd0, camera_regs[REG_CLIP][31:0]});
            farv = longint'({32'd0, camera_regs[REG_CLIP][63:32]});
            if (depth <= 0 || depth < nearv || depth > farv) begin
                e.px = '0;
                e.py = '0;
                e.pr = '0;
                e.clip = 1'b1;
            end else begin
                lt = axis_dot(dx, dy, dz, camera_regs[REG_LEFT]);
                ut = axis_dot(dx, dy, dz, camera_regs[REG_UP]);
                width = longint'({52'd0, camera_regs[REG_IMAGE][11:0]});
                height = longint'({52'd0, camera_regs[REG_IMAGE][23:12]});
                scale = {32'd0, camera_regs[REG_IMAGE][55:24]};
                radius = {32'd0, pt[127:96]};
                xq = div_floor((depth + lt) * width * 128, depth);
                yq = (height - 1) * 256 - div_floor((depth + ut) * height * 128, depth);
                rq = (radius * scale) / (longint'(depth) * 256);
                if (rq > 64'hFFFF_FFFF) rq = 64'hFFFF_FFFF;
                if (rq < 1) rq = 1;
                e.px = clamp_s32(xq);
                e.py = clamp_s32(yq);
                e.pr = rq[31:0];
                e.clip = 1'b0;
            end
            owed.push_back(e);
        endfunction

        // Compare one result transaction with the oldest projection owed.
        function void check_pixel(logic [95:0] data, logic clip);
            pixel_t e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result, actual %h clip %b", $realtime, data, clip);
                errors++;
                return;
            end
            e = owed.pop_front();
            checked++;
            if (clip) clipped_seen++;
            if (data[31:0] !== e.px) begin
                $display("%0t: pixel_x expected %h actual %h", $realtime, e.px, data[31:0]);
                errors++;
            end
            if (data[63:32] !== e.py) begin
                $display("%0t: pixel_y expected %h actual %h", $realtime, e.py, data[63:32]);
                errors++;
            end
            if (data[95:64] !== e.pr) begin
                $display("%0t: pixel_radius expected %h actual %h",
                         $realtime, e.pr, data[95:64]);
                errors++;
            end
            if (clip !== e.clip) begin
                $display("%0t: clipped expected %b actual %b", $realtime, e.clip, clip);
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [5:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    projection_board board = new();
    bit calm;
    int sent;

    perspective_point_projector DUT (.*);

    // 10 ns clock.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // The receiver stalls about a third of the time, except in a calm stretch.
    always @(posedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 34);
        end
    end

    // Check every result transaction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_pixel(m_tdata, m_tuser[0]);
    end

    // Hard limit on the run.
    initial begin
        #3ms;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [63:0] axis3(int ax, int ay, int az);
        return {1'b0, az[20:0], ay[20:0], ax[20:0]};
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        board.camera_regs[idx] = value;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stop sending, then wait until every owed projection has come back
    // and the pipeline is empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.owed.size() != 0) @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    task automatic send_point(logic [127:0] pt);
        int gap;
        if (!calm && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pt;
        do @(posedge aclk); while (!s_tready);
        board.note_point(pt);
        sent++;
    endtask

    // A point roughly inside the view of the standard camera.
    function automatic logic [127:0] framed_point();
        int z, x, y;
        z = $urandom_range(1, 2000) << 12;
        x = $signed($urandom_range(0, 2 * z)) - z;
        y = $signed($urandom_range(0, 2 * z)) - z;
        return {$urandom(), z + 32'(32'sh0001_0000 * 0), y, x};
    endfunction

    task automatic standard_camera(logic [11:0] w, logic [11:0] h, logic [31:0] scale);
        write_reg(REG_CAM_X, 64'd0);
        write_reg(REG_CAM_Y, 64'd0);
        write_reg(REG_CAM_Z, 64'd0);
        write_reg(REG_VIEW, axis3(0, 0, 65536));
        write_reg(REG_LEFT, axis3(65536, 0, 0));
        write_reg(REG_UP, axis3(0, 65536, 0));
        write_reg(REG_CLIP, {32'h7FFF_FFFF, 32'h0000_1000});
        write_reg(REG_IMAGE, {8'd0, scale, h, w});
    endtask

    task automatic random_camera();
        write_reg(REG_CAM_X, 64'($urandom()));
        write_reg(REG_CAM_Y, 64'($urandom()));
        write_reg(REG_CAM_Z, 64'($urandom()));
        write_reg(REG_VIEW, {1'b0, 31'($urandom()), $urandom()});
        write_reg(REG_LEFT, {1'b0, 31'($urandom()), $urandom()});
        write_reg(REG_UP, {1'b0, 31'($urandom()), $urandom()});
        write_reg(REG_CLIP, {1'b0, 31'($urandom()), 32'($urandom_range(0, 65535))});
        write_reg(REG_IMAGE, {8'd0, 24'($urandom()), $urandom()});
    endtask

    task automatic random_points(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 75) begin
                send_point(framed_point());
            end else begin
                send_point({$urandom(), $urandom(), $urandom(), $urandom()});
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        sent = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers at reset: zero depth, so every point is clipped.
        send_point({32'd1, 32'd0, 32'd0, 32'd0});
        drain();

        // Directed points through a plain forward-looking camera.
        standard_camera(12'd640, 12'd480, 32'h0200_0000);
        send_point({32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_point({32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000});
        send_point({32'd0, 32'h0000_1000, 32'd0, 32'd0});
        send_point({32'd0, 32'h0000_0FFF, 32'd0, 32'd0});
        send_point({32'd5, 32'h0000_0000, 32'd0, 32'd0});
        send_point({32'd0, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000});
        send_point({32'hFFFF_FFFF, 32'h0000_1000, 32'h8000_0000, 32'h7FFF_FFFF});
        send_point({32'h0001_0000, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000});
        drain();
        // Near at zero: zero depth still clips; reversed interval clips everything.
        write_reg(REG_CLIP, {32'hFFFF_FFFF, 32'h0000_0000});
        send_point({32'd7, 32'd0, 32'd3, 32'd3});
        send_point({32'd7, 32'h0000_0001, 32'd3, 32'd3});
        drain();
        write_reg(REG_CLIP, {32'h0000_1000, 32'h0010_0000});
        send_point({32'd7, 32'h0008_0000, 32'd3, 32'd3});
        drain();
        // Zero image size and extreme image size.
        standard_camera(12'd0, 12'd0, 32'd0);
        send_point({32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000});
        drain();
        standard_camera(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
        send_point({32'hFFFF_FFFF, 32'h0000_1000, 32'h7FFF_FFFF, 32'h8000_0000});
        send_point({32'hFFFF_FFFF, 32'h0000_1000, 32'h8000_0000, 32'h7FFF_FFFF});
        drain();

        // Random phases under several camera settings.
        standard_camera(12'd640, 12'd480, 32'h0200_0000);
        calm = 1'b1;
        random_points(150);
        calm = 1'b0;
        random_points(200);
        drain();
        standard_camera(12'($urandom()), 12'($urandom()), $urandom());
        write_reg(REG_CAM_X, 64'(($urandom() & 32'hFF) << 16));
        write_reg(REG_LEFT, {1'b0, 21'h1F0000, 21'd0, 21'h1FFFFF});
        random_points(200);
        drain();
        random_camera();
        random_points(100);
        drain();
        write_reg(REG_VIEW, {1'b0, 21'h0FFFFF, 21'h100000, 21'h0FFFFF});
        write_reg(REG_CLIP, {32'hFFFF_FFFF, 32'd0});
        random_points(100);
        drain();
        standard_camera(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
        random_points(100);
        s_tvalid <= 1'b0;
        drain();

        $display("Sent %0d points, checked %0d projections, %0d of them clipped.",
                 sent, board.checked, board.clipped_seen);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
